[rtl/core/lotp_pkg.sv]
// Shared constants for the list operation transform pair block.
package lotp_pkg;

  localparam logic [1:0] KIND_INS  = 2'd0;
  localparam logic [1:0] KIND_UPD  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int POS_WIDTH_DEF   = 16;
  localparam int TOKEN_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

endpackage

[rtl/core/lotp_front.sv]
// Front end: accepts an operation pair and computes both transformed results.
module lotp_front #(
  parameter int POS_WIDTH   = lotp_pkg::POS_WIDTH_DEF,
  parameter int TOKEN_WIDTH = lotp_pkg::TOKEN_WIDTH_DEF,
  localparam int RW = 3 + 2 * POS_WIDTH + 3 * TOKEN_WIDTH
) (
  input  logic                          op_valid,
  output logic                          op_ready,
  input  logic [1:0]                    client_kind,
  input  logic signed [POS_WIDTH-1:0]   client_pos,
  input  logic signed [POS_WIDTH-1:0]   client_new_pos,
  input  logic [TOKEN_WIDTH-1:0]        client_id,
  input  logic [TOKEN_WIDTH-1:0]        client_element,
  input  logic [1:0]                    server_kind,
  input  logic signed [POS_WIDTH-1:0]   server_pos,
  input  logic signed [POS_WIDTH-1:0]   server_new_pos,
  input  logic [TOKEN_WIDTH-1:0]        server_id,
  input  logic [TOKEN_WIDTH-1:0]        server_element,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [2*RW-1:0]               q_data
);

  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam logic signed [POS_WIDTH-1:0] NEG_ONE = '1;

  function automatic logic signed [POS_WIDTH-1:0] inc(input logic signed [POS_WIDTH-1:0] p);
    inc = (p == POS_MAX) ? p : p + POS_WIDTH'(1);
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] dec(input logic signed [POS_WIDTH-1:0] p);
    dec = (p == POS_MIN) ? p : p - POS_WIDTH'(1);
  endfunction

  logic [1:0]                  fk, gk;
  logic signed [POS_WIDTH-1:0] fp, fn, gp, gn;
  logic [TOKEN_WIDTH-1:0]      fid, fpar, fel, gid, gpar, gel;
  logic                        ok;
  logic signed [POS_WIDTH-1:0] cp, sp, cn, sn;
  logic [RW-1:0]               f_res, g_res;

  assign cp = client_pos;
  assign sp = server_pos;
  assign cn = client_new_pos;
  assign sn = server_new_pos;

  always_comb begin
    fk = server_kind; fp = sp; fn = sn; fid = server_id; fpar = client_id; fel = server_element;
    gk = client_kind; gp = cp; gn = cn; gid = client_id; gpar = server_id; gel = client_element;
    ok = 1'b1;
    if (client_kind == lotp_pkg::KIND_INS && server_kind == lotp_pkg::KIND_INS) begin
      if (cp <= sp) fp = inc(fp);
      else gp = inc(gp);
    end else if (client_kind == lotp_pkg::KIND_UPD && server_kind == lotp_pkg::KIND_UPD) begin
      if (cp == sp) begin
        gk = server_kind; gp = sp; gn = sn; gel = server_element;
      end
      if (cp < sp && cn > sp) begin
        fp = dec(fp);
        if (cn >= sn) fn = dec(fn);
      end else if (cn >= sn) begin
        fn = dec(fn);
      end
      if (sp < cp && sn > cp) begin
        gp = dec(gp);
        if (sn >= cn) gn = dec(gn);
      end else if (sn >= cn) begin
        gn = dec(gn);
      end
    end else if (client_kind == lotp_pkg::KIND_INS && server_kind == lotp_pkg::KIND_UPD) begin
      if (sp >= cp) fp = inc(fp);
    end else if (client_kind == lotp_pkg::KIND_UPD && server_kind == lotp_pkg::KIND_INS) begin
      if (sp <= cp) gp = inc(gp);
    end else if (client_kind == lotp_pkg::KIND_DEL && server_kind == lotp_pkg::KIND_DEL) begin
      if (cp < sp) fp = dec(fp);
      else if (cp > sp) gp = dec(gp);
      else begin
        fp = NEG_ONE; gp = NEG_ONE;
      end
    end else if (client_kind == lotp_pkg::KIND_INS && server_kind == lotp_pkg::KIND_DEL) begin
      if (cp <= sp) fp = inc(fp);
      else if (sp != NEG_ONE) gp = dec(gp);
    end else if (client_kind == lotp_pkg::KIND_DEL && server_kind == lotp_pkg::KIND_INS) begin
      if (sp <= cp) gp = inc(gp);
      else if (cp != NEG_ONE) fp = dec(fp);
    end else if (client_kind == lotp_pkg::KIND_UPD && server_kind == lotp_pkg::KIND_DEL) begin
      if (cp == sp) begin
        gk = lotp_pkg::KIND_DEL; gp = NEG_ONE; gn = '0; gel = server_element;
      end else if (cp > sp && cn <= sp) begin
        gp = dec(gp);
      end else if (cp < sp && cn >= sp) begin
        gn = dec(gn);
      end else if (cp > sp) begin
        gp = dec(gp); gn = dec(gn);
      end
    end else if (client_kind == lotp_pkg::KIND_DEL && server_kind == lotp_pkg::KIND_UPD) begin
      if (cp == sp) begin
        fk = lotp_pkg::KIND_DEL; fp = NEG_ONE; fn = '0; fel = client_element;
      end else if (cp < sp && cp >= sn) begin
        fp = dec(fp);
      end else if (cp > sp && cp <= sn) begin
        fn = dec(fn);
      end else if (cp < sp) begin
        fp = dec(fp); fn = dec(fn);
      end
    end else begin
      ok = 1'b0;
    end
  end

  always_comb begin
    if (ok) begin
      f_res = {1'b1, fk, fp, (fk == lotp_pkg::KIND_UPD) ? fn : '0, fid, fpar, fel};
      g_res = {1'b1, gk, gp, (gk == lotp_pkg::KIND_UPD) ? gn : '0, gid, gpar, gel};
    end else begin
      f_res = '0;
      g_res = '0;
    end
  end

  assign op_ready = !q_full;
  assign q_push   = op_valid && !q_full;
  assign q_data   = {g_res, f_res};

endmodule

[rtl/core/lotp_queue.sv]
// Short queue of transformed result pairs between front and back.
module lotp_queue #(
  parameter int WIDTH = 8,
  localparam int DEPTH = lotp_pkg::QUEUE_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      if (push && !pop) count <= count + (AW+1)'(1);
      else if (pop && !push) count <= count - (AW+1)'(1);
    end
  end

endmodule

[rtl/core/lotp_back.sv]
// Back end: plays out each queued pair as server result then client result.
module lotp_back #(
  parameter int POS_WIDTH   = lotp_pkg::POS_WIDTH_DEF,
  parameter int TOKEN_WIDTH = lotp_pkg::TOKEN_WIDTH_DEF,
  localparam int RW = 3 + 2 * POS_WIDTH + 3 * TOKEN_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [2*RW-1:0]             q_head,
  output logic                        q_pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [1:0]                  out_kind,
  output logic signed [POS_WIDTH-1:0] out_pos,
  output logic signed [POS_WIDTH-1:0] out_new_pos,
  output logic [TOKEN_WIDTH-1:0]      out_id,
  output logic [TOKEN_WIDTH-1:0]      out_parent,
  output logic [TOKEN_WIDTH-1:0]      out_element,
  output logic                        out_valid,
  output logic                        out_last
);

  logic          half;
  logic          load;
  logic [RW-1:0] sel;
  logic [RW-1:0] res;

  assign load  = !res_valid || res_ready;
  assign q_pop = load && !q_empty && half;
  assign sel   = half ? q_head[2*RW-1:RW] : q_head[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      res_valid <= !q_empty;
      if (!q_empty) half <= !half;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      res      <= sel;
      out_last <= half;
    end
  end

  assign {out_valid, out_kind, out_pos, out_new_pos, out_id, out_parent, out_element} = res;

endmodule

[rtl/core/list_op_transform_pair_top.sv]
// Top level of the list operation transform pair block.
//
// Input channel (op_valid/op_ready) carries one concurrent client/server
// operation pair per transfer. Output channel (res_valid/res_ready) returns two
// results per pair: the transformed server operation (out_last 0), then the
// transformed client operation (out_last 1). Unsupported kind pairs give two
// results with out_valid 0 and all other fields zero.
// The front computes both results in the cycle of the input transfer and
// writes them into a two-entry queue; the back plays each entry out as two
// results through an output register. Each result passes through the queue
// entry and then the output register. The single result port returns one
// result at a time and so sets throughput; the queue takes new pairs meanwhile.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// When the receiver stalls, the output register holds its result; the front
// keeps taking pairs until the queue is full, then drops op_ready.
module list_op_transform_pair_top #(
  parameter int POS_WIDTH   = lotp_pkg::POS_WIDTH_DEF,
  parameter int TOKEN_WIDTH = lotp_pkg::TOKEN_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  logic [1:0]                  client_kind,
  input  logic signed [POS_WIDTH-1:0] client_pos,
  input  logic signed [POS_WIDTH-1:0] client_new_pos,
  input  logic [TOKEN_WIDTH-1:0]      client_id,
  input  logic [TOKEN_WIDTH-1:0]      client_element,
  input  logic [1:0]                  server_kind,
  input  logic signed [POS_WIDTH-1:0] server_pos,
  input  logic signed [POS_WIDTH-1:0] server_new_pos,
  input  logic [TOKEN_WIDTH-1:0]      server_id,
  input  logic [TOKEN_WIDTH-1:0]      server_element,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [1:0]                  out_kind,
  output logic signed [POS_WIDTH-1:0] out_pos,
  output logic signed [POS_WIDTH-1:0] out_new_pos,
  output logic [TOKEN_WIDTH-1:0]      out_id,
  output logic [TOKEN_WIDTH-1:0]      out_parent,
  output logic [TOKEN_WIDTH-1:0]      out_element,
  output logic                        out_valid,
  output logic                        out_last
);

  localparam int RW = 3 + 2 * POS_WIDTH + 3 * TOKEN_WIDTH;

  logic            q_full, q_push, q_pop, q_empty;
  logic [2*RW-1:0] q_data, q_head;

  lotp_front #(.POS_WIDTH(POS_WIDTH), .TOKEN_WIDTH(TOKEN_WIDTH)) u_front (
    .op_valid       (op_valid),
    .op_ready       (op_ready),
    .client_kind    (client_kind),
    .client_pos     (client_pos),
    .client_new_pos (client_new_pos),
    .client_id      (client_id),
    .client_element (client_element),
    .server_kind    (server_kind),
    .server_pos     (server_pos),
    .server_new_pos (server_new_pos),
    .server_id      (server_id),
    .server_element (server_element),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  lotp_queue #(.WIDTH(2 * RW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  lotp_back #(.POS_WIDTH(POS_WIDTH), .TOKEN_WIDTH(TOKEN_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_kind    (out_kind),
    .out_pos     (out_pos),
    .out_new_pos (out_new_pos),
    .out_id      (out_id),
    .out_parent  (out_parent),
    .out_element (out_element),
    .out_valid   (out_valid),
    .out_last    (out_last)
  );

endmodule
